@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ilp_pkg.sv @@
package ilp_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX,
    BASE_BIN
  } base_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_LONE_MINUS = 3'd2,
    ST_BAD_DIGIT  = 3'd3,
    ST_NO_DIGITS  = 3'd4,
    ST_RANGE      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } char_t;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // marks a character that is not a hex digit
  localparam logic [4:0] HEX_NONE = 5'd16;

  localparam logic [7:0] COUNT_MAX = 8'hff;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] d;
    d = HEX_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = 5'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = 5'(c - CH_LA) + 5'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = 5'(c - CH_UA) + 5'd10;
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_of(input base_e b);
    logic [4:0] r;
    case (b)
      BASE_OCT: r = 5'd8;
      BASE_HEX: r = 5'd16;
      BASE_BIN: r = 5'd2;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ilp_char_if.sv @@
interface ilp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

@@ hw/rtl/ilp_result_if.sv @@
interface ilp_result_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [2:0]            status;
  logic [7:0]            consumed;

  modport source  (output valid, output value, output status, output consumed, input ready);
  modport sink    (input valid, input value, input status, input consumed, output ready);
  modport monitor (input valid, input value, input status, input consumed, input ready);
endinterface

@@ hw/rtl/ilp_in_stage.sv @@
module ilp_in_stage import ilp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ilp_char_if.sink in_i,
  input  logic  take_i,
  output logic  valid_o,
  output char_t char_o
);

  logic  valid_q, valid_d;
  char_t char_q;
  logic  accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q.ch        <= in_i.ch;
      char_q.last_char <= in_i.last_char;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

@@ hw/rtl/ilp_parse.sv @@
module ilp_parse import ilp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ch_valid_i,
  input  char_t                 ch_i,
  input  logic                  out_free_i,
  output logic                  ch_take_o,
  output logic                  res_valid_o,
  output logic [VALUE_BITS-1:0] res_value_o,
  output status_e               res_status_o,
  output logic [7:0]            res_consumed_o
);

  localparam int unsigned PW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] MaxMag = {1'b0, {(VALUE_BITS-1){1'b1}}};

  phase_e                phase_q, phase_d;
  base_e                 base_q, base_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  ovf_q, ovf_d;
  logic                  bad_q, bad_d;
  logic                  seen_q, seen_d;
  logic [7:0]            count_q, count_d;

  logic                  take;
  logic                  is_minus, is_zero, is_x, is_b;
  logic [4:0]            digit;
  base_e                 eff_base;
  logic                  digit_path, digit_ok, digit_fit, digit_valid;
  logic [PW-1:0]         mag_w, scaled, acc;
  logic                  too_big;
  logic                  count_inc;
  logic [7:0]            head;

  assign take        = ch_valid_i && (!ch_i.last_char || out_free_i);
  assign ch_take_o   = take;
  assign res_valid_o = ch_valid_i && ch_i.last_char && out_free_i;

  // character decode and shift-add
  always_comb begin
    is_minus = (ch_i.ch == CH_MINUS);
    is_zero  = (ch_i.ch == CH_0);
    is_x     = (ch_i.ch == CH_LX) || (ch_i.ch == CH_UX);
    is_b     = (ch_i.ch == CH_LB) || (ch_i.ch == CH_UB);
    digit    = hex_val(ch_i.ch);

    case (phase_q)
      PH_START:  digit_path = !is_minus && !is_zero;
      PH_SIGN:   digit_path = !is_zero;
      PH_ZERO:   digit_path = !is_x && !is_b;
      PH_DIGITS: digit_path = 1'b1;
      default:   digit_path = 1'b0;
    endcase

    case (phase_q)
      PH_START, PH_SIGN: eff_base = BASE_DEC;
      PH_ZERO:           eff_base = BASE_OCT;
      default:           eff_base = base_q;
    endcase

    digit_ok    = (digit != HEX_NONE);
    digit_fit   = (digit < radix_of(eff_base));
    digit_valid = digit_ok && digit_fit;

    mag_w = PW'(mag_q);
    case (eff_base)
      BASE_OCT: scaled = mag_w << 3;
      BASE_HEX: scaled = mag_w << 4;
      BASE_BIN: scaled = mag_w << 1;
      default:  scaled = (mag_w << 3) + (mag_w << 1);
    endcase
    acc     = scaled + PW'(digit);
    too_big = (acc > PW'(MaxMag));
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (digit_path) begin
      phase_d = digit_valid ? PH_DIGITS : PH_DONE;
    end else begin
      case (phase_q)
        PH_START: phase_d = is_minus ? PH_SIGN : PH_ZERO;
        PH_SIGN:  phase_d = PH_ZERO;
        PH_ZERO:  phase_d = PH_DIGITS;
        default:  phase_d = phase_q;
      endcase
    end
  end

  // accumulator and flags
  always_comb begin
    base_d = base_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    ovf_d  = ovf_q;
    bad_d  = bad_q;
    seen_d = seen_q;

    count_inc = digit_path ? digit_valid : (phase_q != PH_DONE);
    count_d   = (count_inc && count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;

    if (phase_q == PH_START && is_minus) begin
      neg_d = 1'b1;
    end

    if (digit_path) begin
      if (phase_q == PH_ZERO) begin
        base_d = BASE_OCT;
      end else if (phase_q == PH_START || phase_q == PH_SIGN) begin
        base_d = BASE_DEC;
      end
      if (digit_ok && !digit_fit) begin
        bad_d = 1'b1;
      end
      if (digit_valid) begin
        seen_d = 1'b1;
        if (!ovf_q) begin
          if (too_big) begin
            ovf_d = 1'b1;
          end else begin
            mag_d = acc[VALUE_BITS-1:0];
          end
        end
      end
    end else if (phase_q == PH_ZERO) begin
      // radix prefix after a leading zero
      base_d = is_x ? BASE_HEX : BASE_BIN;
      seen_d = 1'b0;
    end else if (phase_q == PH_START || phase_q == PH_SIGN) begin
      if (is_zero) begin
        seen_d = 1'b1;
      end
    end
  end

  // result from the state after this character
  always_comb begin
    head = {7'd0, neg_d} + (((base_d == BASE_HEX) || (base_d == BASE_BIN)) ? 8'd2 : 8'd0);
    res_value_o = '0;
    if (phase_d == PH_SIGN) begin
      res_status_o   = ST_LONE_MINUS;
      res_consumed_o = 8'd1;
    end else if (bad_d) begin
      res_status_o   = ST_BAD_DIGIT;
      res_consumed_o = count_d;
    end else if (!seen_d) begin
      res_status_o   = ST_NO_DIGITS;
      res_consumed_o = head;
    end else if (ovf_d) begin
      res_status_o   = ST_RANGE;
      res_consumed_o = head;
    end else begin
      res_status_o   = ST_OK;
      res_consumed_o = count_d;
      res_value_o    = neg_d ? (~mag_d + 1'b1) : mag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      base_q  <= BASE_DEC;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      bad_q   <= 1'b0;
      seen_q  <= 1'b0;
      count_q <= '0;
    end else if (take) begin
      if (ch_i.last_char) begin
        // string done, back to the start state
        phase_q <= PH_START;
        base_q  <= BASE_DEC;
        neg_q   <= 1'b0;
        mag_q   <= '0;
        ovf_q   <= 1'b0;
        bad_q   <= 1'b0;
        seen_q  <= 1'b0;
        count_q <= '0;
      end else begin
        phase_q <= phase_d;
        base_q  <= base_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        ovf_q   <= ovf_d;
        bad_q   <= bad_d;
        seen_q  <= seen_d;
        count_q <= count_d;
      end
    end
  end

endmodule

@@ hw/rtl/integer_literal_parser.sv @@
// path: a character is registered in the input stage and parsed combinationally; the
//   result of a string's last character loads into the result register once it is free
// throughput: one character per cycle, set by the combinational shift-add, except that
//   a last character waits while the result register is full and not being read
// reset: asynchronous active low; empties both registers and returns the
//   parser to the start of a string
module integer_literal_parser import ilp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ilp_char_if.sink     in_i,
  ilp_result_if.source out_o
);

  logic                  s1_valid;
  char_t                 s1_char;
  logic                  s1_take;
  logic                  out_free;
  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_value;
  status_e               res_status;
  logic [7:0]            res_consumed;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [2:0]            out_status_q;
  logic [7:0]            out_consumed_q;

  ilp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .char_o  (s1_char)
  );

  ilp_parse #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ch_valid_i     (s1_valid),
    .ch_i           (s1_char),
    .out_free_i     (out_free),
    .ch_take_o      (s1_take),
    .res_valid_o    (res_valid),
    .res_value_o    (res_value),
    .res_status_o   (res_status),
    .res_consumed_o (res_consumed)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_valid_d = out_free ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_value_q    <= res_value;
      out_status_q   <= res_status;
      out_consumed_q <= res_consumed;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.status   = out_status_q;
  assign out_o.consumed = out_consumed_q;

endmodule

@@ hw/rtl/ilp_checker.sv @@
`include "assert_macros.svh"

module ilp_checker import ilp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_i,
  input logic                  ready_i,
  input logic [VALUE_BITS-1:0] value_i,
  input logic [2:0]            status_i,
  input logic [7:0]            consumed_i
);

  localparam logic [VALUE_BITS-1:0] MinNeg = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic status_legal;
  logic stall;

  // every string has a character, so empty never shows
  assign status_legal = (status_i != ST_EMPTY) && (status_i <= ST_RANGE);
  assign stall        = valid_i && !ready_i;

  `ASSERT_IMPL(a_status_code, clk_i, rst_ni, valid_i, status_legal)
  `ASSERT_IMPL(a_err_value_zero, clk_i, rst_ni, valid_i && status_i != ST_OK, value_i == '0)
  `ASSERT_IMPL(a_ok_in_range, clk_i, rst_ni, valid_i && status_i == ST_OK, value_i != MinNeg)
  `ASSERT_IMPL(a_lone_minus_one, clk_i, rst_ni, valid_i && status_i == ST_LONE_MINUS, consumed_i == 8'd1)
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stall, valid_i && $stable({value_i, status_i, consumed_i}))

endmodule

bind integer_literal_parser ilp_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_ilp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (out_o.valid),
  .ready_i    (out_o.ready),
  .value_i    (out_o.value),
  .status_i   (out_o.status),
  .consumed_i (out_o.consumed)
);

@@ bench/integer_literal_parser_tb.sv @@
`timescale 1ns / 1ps

module integer_literal_parser_tb;
  import ilp_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
    logic [7:0]  consumed;
  } literal_t;

  typedef logic [7:0] byte_q_t[$];

  localparam longint unsigned MAG_MAX = 64'd2147483647;

  logic clk_i;
  logic rst_ni;

  ilp_char_if char_if ();
  ilp_result_if #(.VALUE_BITS(32)) lit_if ();

  integer_literal_parser #(.VALUE_BITS(32)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_if),
    .out_o (lit_if)
  );

  char_t    pending_chars[$];
  literal_t literal_q[$];
  int       src_idle_pct;
  int       snk_stall_pct;
  int       mismatch_count;

  // parser state mirrored by the predictor
  phase_e          lit_phase;
  base_e           num_base;
  bit              neg_flag;
  longint unsigned mag;
  bit              ovf_flag;
  bit              bad_flag;
  bit              seen_digit;
  logic [7:0]      char_cnt;

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    lit_phase  = PH_START;
    num_base   = BASE_DEC;
    neg_flag   = 1'b0;
    mag        = '0;
    ovf_flag   = 1'b0;
    bad_flag   = 1'b0;
    seen_digit = 1'b0;
    char_cnt   = '0;
  endfunction

  // 16 for anything that is not a hex digit
  function automatic int unsigned hex_digit(logic [7:0] c);
    int unsigned d;
    d = 16;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 10;
    end
    return d;
  endfunction

  function automatic int unsigned base_radix(base_e b);
    int unsigned r;
    case (b)
      BASE_OCT: r = 8;
      BASE_HEX: r = 16;
      BASE_BIN: r = 2;
      default:  r = 10;
    endcase
    return r;
  endfunction

  function automatic void bump_count();
    if (char_cnt != COUNT_MAX) begin
      char_cnt++;
    end
  endfunction

  function automatic void take_digit(logic [7:0] c);
    int unsigned d;
    int unsigned r;
    d = hex_digit(c);
    r = base_radix(num_base);
    if (d >= 16) begin
      lit_phase = PH_DONE;
      return;
    end
    if (d >= r) begin
      bad_flag  = 1'b1;
      lit_phase = PH_DONE;
      return;
    end
    seen_digit = 1'b1;
    bump_count();
    if (!ovf_flag) begin
      if (mag > (MAG_MAX - d) / r) begin
        ovf_flag = 1'b1;
      end else begin
        mag = mag * r + d;
      end
    end
    lit_phase = PH_DIGITS;
  endfunction

  // advances the mirrored parser by one character; 1 when a literal completes
  function automatic bit parse_char(input char_t item, output literal_t res);
    logic [7:0]  c;
    logic [7:0]  head;
    c   = item.ch;
    res = '{value: '0, status: ST_OK, consumed: '0};
    case (lit_phase)
      PH_START, PH_SIGN: begin
        if (lit_phase == PH_START && c == CH_MINUS) begin
          neg_flag  = 1'b1;
          bump_count();
          lit_phase = PH_SIGN;
        end else if (c == CH_0) begin
          bump_count();
          seen_digit = 1'b1;
          lit_phase  = PH_ZERO;
        end else begin
          num_base = BASE_DEC;
          take_digit(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          num_base   = BASE_HEX;
          seen_digit = 1'b0;
          bump_count();
          lit_phase  = PH_DIGITS;
        end else if (c == CH_LB || c == CH_UB) begin
          num_base   = BASE_BIN;
          seen_digit = 1'b0;
          bump_count();
          lit_phase  = PH_DIGITS;
        end else begin
          num_base = BASE_OCT;
          take_digit(c);
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
    if (!item.last_char) begin
      return 1'b0;
    end
    head = 8'(neg_flag) + ((num_base == BASE_HEX || num_base == BASE_BIN) ? 8'd2 : 8'd0);
    if (lit_phase == PH_SIGN) begin
      res.status   = ST_LONE_MINUS;
      res.consumed = 8'd1;
    end else if (bad_flag) begin
      res.status   = ST_BAD_DIGIT;
      res.consumed = char_cnt;
    end else if (!seen_digit) begin
      res.status   = ST_NO_DIGITS;
      res.consumed = head;
    end else if (ovf_flag) begin
      res.status   = ST_RANGE;
      res.consumed = head;
    end else begin
      res.status   = ST_OK;
      res.consumed = char_cnt;
      res.value    = neg_flag ? 32'(64'd0 - mag) : 32'(mag);
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void push_literal(byte_q_t bytes);
    char_t item;
    foreach (bytes[i]) begin
      item.ch        = bytes[i];
      item.last_char = (i == bytes.size() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic void push_text(string s);
    byte_q_t bytes;
    for (int i = 0; i < s.len(); i++) begin
      bytes.push_back(s[i]);
    end
    push_literal(bytes);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d, bit upper);
    if (d < 10) begin
      return CH_0 + 8'(d);
    end
    return (upper ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (hex_digit(c) != 16);
    return c;
  endfunction

  function automatic void random_literal();
    byte_q_t     bytes;
    base_e       b;
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned d;
    longint unsigned v;
    string       s;
    kind = $urandom_range(0, 99);
    b    = base_e'($urandom_range(0, 3));
    r    = base_radix(b);
    if (kind < 12) begin
      // pure noise
      n = $urandom_range(1, 4);
      repeat (n) bytes.push_back(8'($urandom));
      push_literal(bytes);
      return;
    end
    if ($urandom_range(0, 99) < 35) begin
      bytes.push_back(CH_MINUS);
    end
    if (b == BASE_HEX || b == BASE_BIN || b == BASE_OCT) begin
      bytes.push_back(CH_0);
    end
    if (b == BASE_HEX) begin
      bytes.push_back($urandom_range(0, 1) ? CH_UX : CH_LX);
    end else if (b == BASE_BIN) begin
      bytes.push_back($urandom_range(0, 1) ? CH_UB : CH_LB);
    end
    if (kind < 30) begin
      // magnitudes around the top of the signed range
      v = MAG_MAX + $urandom_range(0, 6) - 3;
      case (b)
        BASE_HEX: begin
          s = $sformatf("%0h", v);
          if ($urandom_range(0, 1)) begin
            s = s.toupper();
          end
        end
        BASE_OCT: s = $sformatf("%0o", v);
        BASE_BIN: s = $sformatf("%0b", v);
        default:  s = $sformatf("%0d", v);
      endcase
      for (int i = 0; i < s.len(); i++) begin
        bytes.push_back(s[i]);
      end
    end else begin
      case (b)
        BASE_HEX: n = 9;
        BASE_OCT: n = 12;
        BASE_BIN: n = 33;
        default:  n = 11;
      endcase
      n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        d = (b == BASE_DEC && i == 0) ? $urandom_range(1, 9) : $urandom_range(0, r - 1);
        bytes.push_back(digit_char(d, $urandom_range(0, 1)));
      end
      if (b != BASE_HEX && $urandom_range(0, 99) < 15) begin
        bytes.push_back(digit_char($urandom_range(r, 15), $urandom_range(0, 1)));
      end
    end
    if ($urandom_range(0, 1)) begin
      bytes.push_back(non_hex_char());
      n = $urandom_range(0, 3);
      repeat (n) bytes.push_back(8'($urandom));
    end
    push_literal(bytes);
  endfunction

  // driver: presents pending characters, predicts each accepted one
  always @(posedge clk_i) begin
    char_t    cur;
    literal_t res;
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        cur.ch        = char_if.ch;
        cur.last_char = char_if.last_char;
        if (parse_char(cur, res)) begin
          literal_q.push_back(res);
        end
      end
      if (!char_if.valid || char_if.ready) begin
        if (pending_chars.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur                = pending_chars.pop_front();
          char_if.valid     <= 1'b1;
          char_if.ch        <= cur.ch;
          char_if.last_char <= cur.last_char;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    literal_t exp_lit;
    if (!rst_ni) begin
      lit_if.ready <= 1'b0;
    end else begin
      if (lit_if.valid && lit_if.ready) begin
        if (literal_q.size() == 0) begin
          $error("unexpected result: value %0d status %0d consumed %0d",
                 $signed(lit_if.value), lit_if.status, lit_if.consumed);
          mismatch_count++;
        end else begin
          exp_lit = literal_q.pop_front();
          if (lit_if.value !== exp_lit.value) begin
            $error("value: expected %0d, actual %0d",
                   $signed(exp_lit.value), $signed(lit_if.value));
            mismatch_count++;
          end
          if (lit_if.status !== exp_lit.status) begin
            $error("status: expected %0d, actual %0d", exp_lit.status, lit_if.status);
            mismatch_count++;
          end
          if (lit_if.consumed !== exp_lit.consumed) begin
            $error("consumed: expected %0d, actual %0d", exp_lit.consumed, lit_if.consumed);
            mismatch_count++;
          end
        end
      end
      lit_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin
    byte_q_t bytes;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.ch        = '0;
    char_if.last_char = 1'b0;
    lit_if.ready      = 1'b0;
    mismatch_count    = 0;
    src_idle_pct      = 18;
    snk_stall_pct     = 67;
    clear_parser();

    push_text("-");
    push_text("0");
    push_text("-0");
    push_text("00");
    push_text("0x");
    push_text("-0b");
    push_text("-,");
    push_text("--");
    push_text("0x7fffffff");
    push_text("-2147483647");
    push_text("2147483648");
    push_text("-0x80000000");
    push_text("0b1011");
    push_text("0B");
    push_text("0777");
    push_text("019");
    push_text("0b102");
    push_text("12a");
    push_text("0xFFz-9");
    push_text("0X1aF");
    push_text("9");
    bytes = '{8'h00};
    push_literal(bytes);
    bytes = '{8'hff};
    push_literal(bytes);
    bytes = '{CH_0 + 8'd5, 8'hff, 8'h00};
    push_literal(bytes);
    // long octal run of zeros drives the consumed count into saturation
    bytes = {};
    repeat (300) bytes.push_back(CH_0);
    push_literal(bytes);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 18 : (p == 1) ? 67 : 0;
      snk_stall_pct = (p == 0) ? 67 : (p == 1) ? 18 : 0;
      while (pending_chars.size() < 530) begin
        random_literal();
      end
      while (pending_chars.size() != 0 || char_if.valid || literal_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && literal_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
